// File: design/sha256_pkg.sv
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       put_byte;   // write byte_val at block position pos
    logic [7:0] byte_val;
    logic       count_inc;  // advance byte counter
    logic       start;      // load working vars from the chain
    logic       round;      // run one round
    logic       fold;       // add working vars into chain
    logic       shift_out;  // rotate chain words for output
    logic       reinit;     // restore initial hash, clear count
  } cmd_t;

  typedef struct packed {
    logic [5:0]  pos;        // byte position within the block
    logic [63:0] bit_len;    // byte count times eight
  } status_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// File: design/sha256_if.sv
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       message_end;
  modport source (output valid, data_byte, byte_present, message_end, input ready);
  modport sink (input valid, data_byte, byte_present, message_end, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        digest_last;
  modport source (output valid, digest_word, digest_last, input ready);
  modport sink (input valid, digest_word, digest_last, output ready);
endinterface

// File: design/sha256_datapath.sv
module sha256_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sha256_pkg::cmd_t      cmd,
  input  logic [5:0]            round_idx,
  output sha256_pkg::status_t   status,
  output logic [31:0]           chain_head
);

  logic [31:0] chain_r [8];
  logic [31:0] wv_r [8];
  logic [31:0] win_r [16];
  logic [60:0] count_r;
  logic [5:0]  pos_r;

  logic [31:0] s0w, s1w, wnew, wcur;
  logic [31:0] t1, t2, bs0, bs1, ch, mj;
  logic [1:0]  lane;

  assign status.pos     = pos_r;
  assign status.bit_len = {count_r, 3'b000};
  assign chain_head     = chain_r[0];
  assign lane           = pos_r[1:0];

  always_comb begin
    wcur = win_r[0];
    s0w  = sha256_pkg::ror(win_r[1], 7) ^ sha256_pkg::ror(win_r[1], 18) ^ (win_r[1] >> 3);
    s1w  = sha256_pkg::ror(win_r[14], 17) ^ sha256_pkg::ror(win_r[14], 19)
         ^ (win_r[14] >> 10);
    wnew = win_r[0] + s0w + win_r[9] + s1w;
    bs1  = sha256_pkg::ror(wv_r[4], 6) ^ sha256_pkg::ror(wv_r[4], 11)
         ^ sha256_pkg::ror(wv_r[4], 25);
    ch   = (wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]);
    t1   = wv_r[7] + bs1 + ch + sha256_pkg::ROUND_K[round_idx] + wcur;
    bs0  = sha256_pkg::ror(wv_r[0], 2) ^ sha256_pkg::ror(wv_r[0], 13)
         ^ sha256_pkg::ror(wv_r[0], 22);
    mj   = (wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]);
    t2   = bs0 + mj;
  end

  // Byte entry writes each byte into its word and lane of the 16-word window; rounds then slide it as the schedule.
  always_ff @(posedge clk) begin
    if (cmd.put_byte) begin
      win_r[pos_r[5:2]][(3 - lane) * 8 +: 8] <= cmd.byte_val;
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) win_r[i] <= win_r[i + 1];
      win_r[15] <= wnew;
    end
    if (cmd.start) begin
      for (int i = 0; i < 8; i++) wv_r[i] <= chain_r[i];
    end else if (cmd.round) begin
      wv_r[7] <= wv_r[6];
      wv_r[6] <= wv_r[5];
      wv_r[5] <= wv_r[4];
      wv_r[4] <= wv_r[3] + t1;
      wv_r[3] <= wv_r[2];
      wv_r[2] <= wv_r[1];
      wv_r[1] <= wv_r[0];
      wv_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reinit) begin
      for (int i = 0; i < 8; i++) chain_r[i] <= sha256_pkg::INIT_HASH[i];
      count_r <= '0;
      pos_r   <= '0;
    end else begin
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) chain_r[i] <= chain_r[i] + wv_r[i];
      end else if (cmd.shift_out) begin
        for (int i = 0; i < 7; i++) chain_r[i] <= chain_r[i + 1];
        chain_r[7] <= chain_r[0];
      end
      if (cmd.put_byte) pos_r <= pos_r + 6'd1;
      if (cmd.count_inc) count_r <= count_r + 61'd1;
    end
  end

endmodule

// File: design/sha256_ctrl.sv
module sha256_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_byte_present,
  input  logic                 in_message_end,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_last,
  input  sha256_pkg::status_t  status,
  output sha256_pkg::cmd_t     cmd,
  output logic [5:0]           round_idx
);

  sha256_pkg::state_t state_r, state_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [2:0] emit_r, emit_nxt;
  logic       padding_r, padding_nxt;
  logic [2:0] len_k;

  assign round_idx = rnd_r;
  assign len_k     = status.pos[2:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sha256_pkg::ST_IDLE;
      rnd_r     <= '0;
      emit_r    <= '0;
      padding_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rnd_r     <= rnd_nxt;
      emit_r    <= emit_nxt;
      padding_r <= padding_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    rnd_nxt     = rnd_r;
    emit_nxt    = emit_r;
    padding_nxt = padding_r;
    cmd         = '0;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    out_last    = 1'b0;
    case (state_r)
      sha256_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_byte_present) begin
            cmd.put_byte  = 1'b1;
            cmd.byte_val  = in_data_byte;
            cmd.count_inc = 1'b1;
          end
          padding_nxt = in_message_end;
          if (in_byte_present && status.pos == 6'd63) begin
            cmd.start = 1'b1;
            state_nxt = sha256_pkg::ST_ROUND;
          end else if (in_message_end) begin
            state_nxt = sha256_pkg::ST_PAD;
          end
          // First pad byte follows the data byte, or is written here if none; a full block compresses first.
          if (in_message_end && !in_byte_present) begin
            cmd.put_byte = 1'b1;
            cmd.byte_val = sha256_pkg::PAD_BYTE;
            state_nxt    = (status.pos == 6'd63) ? sha256_pkg::ST_ROUND : sha256_pkg::ST_PAD;
            cmd.start    = status.pos == 6'd63;
            padding_nxt  = 1'b1;
            emit_nxt     = (status.pos < sha256_pkg::LEN_POS) ? 3'd2 : 3'd1;
          end else if (in_message_end) begin
            emit_nxt = 3'd0;
          end
        end
      end
      sha256_pkg::ST_PAD: begin
        // emit_r while padding: 0 means the 0x80 byte is still due, 1 a block of
        // zeros with the length in the next block, 2 the block ending in the length.
        cmd.put_byte = 1'b1;
        if (emit_r == 3'd0) begin
          cmd.byte_val = sha256_pkg::PAD_BYTE;
          emit_nxt     = (status.pos < sha256_pkg::LEN_POS) ? 3'd2 : 3'd1;
        end else if (emit_r == 3'd2 && status.pos >= sha256_pkg::LEN_POS) begin
          cmd.byte_val = status.bit_len[(7 - len_k) * 8 +: 8];
        end else begin
          cmd.byte_val = 8'h00;
        end
        if (status.pos == 6'd63) begin
          cmd.start = 1'b1;
          state_nxt = sha256_pkg::ST_ROUND;
        end
      end
      sha256_pkg::ST_ROUND: begin
        cmd.round = 1'b1;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == 6'd63) state_nxt = sha256_pkg::ST_FOLD;
      end
      sha256_pkg::ST_FOLD: begin
        cmd.fold = 1'b1;
        if (!padding_r) begin
          state_nxt = sha256_pkg::ST_IDLE;
        end else if (emit_r == 3'd2) begin
          // Length field has been written: this was the final block.
          emit_nxt  = 3'd0;
          state_nxt = sha256_pkg::ST_EMIT;
        end else begin
          // A zero-filled block leads to the block that carries the length.
          if (emit_r == 3'd1) emit_nxt = 3'd2;
          state_nxt = sha256_pkg::ST_PAD;
        end
      end
      sha256_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        out_last  = emit_r == 3'd7;
        if (out_ready) begin
          cmd.shift_out = 1'b1;
          emit_nxt      = emit_r + 3'd1;
          if (emit_r == 3'd7) begin
            cmd.shift_out = 1'b0;
            cmd.reinit    = 1'b1;
            padding_nxt   = 1'b0;
            state_nxt     = sha256_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = sha256_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: design/sha256_message_digest_unit.sv
// SHA-256 digest engine fed one message byte per item.
// Input channel (in_): data_byte, byte_present, message_end. A byte is
// taken only while the controller is idle, not while padding, compressing
// or offering digest words. When the 64th byte of a block arrives, in_ready
// drops while the single round unit runs 64 rounds and folds the result
// into the chain. On message_end the controller writes padding, one byte
// per cycle, up to the end of the block (twice when the length field
// spills into a new block), compresses, and then offers eight digest
// words on the out_ channel, word 0 first, digest_last on the eighth.
// Byte entry and the one-round-per-cycle compression loop do not overlap:
// no byte of the next block is taken until the block is folded in.
// After message_end the first word follows the padding bytes and the
// compression of each remaining block.
// A stalled receiver holds the current word; nothing advances until it is
// taken. No input is accepted while digest words are pending.
// Reset (rst_n low, synchronous) restores the initial hash, clears the
// byte count and returns the controller to idle.
module sha256_message_digest_unit (
  input logic        clk,
  input logic        rst_n,
  sha256_in_if.sink    in_ch,
  sha256_out_if.source out_ch
);

  sha256_pkg::cmd_t    cmd;
  sha256_pkg::status_t status;
  logic [5:0]          round_idx;
  logic [31:0]         chain_head;

  sha256_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_data_byte    (in_ch.data_byte),
    .in_byte_present (in_ch.byte_present),
    .in_message_end  (in_ch.message_end),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_last        (out_ch.digest_last),
    .status          (status),
    .cmd             (cmd),
    .round_idx       (round_idx)
  );

  sha256_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .round_idx  (round_idx),
    .status     (status),
    .chain_head (chain_head)
  );

  assign out_ch.digest_word = chain_head;

endmodule

// File: design/sha256_checker.sv
module sha256_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [31:0] out_word,
  input logic out_last
);

  // Never take input while a digest is being offered.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input open during output");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("word changed under stall");

  // After the last word the engine goes back to taking input.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid && in_ready)
    else $error("no return to idle after last word");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind sha256_message_digest_unit sha256_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_word  (out_ch.digest_word),
  .out_last  (out_ch.digest_last)
);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       message_end;
  } byte_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } digest_item_t;

  localparam int IDLE_LIMIT = 6000;
  localparam int HOLD_OFF   = 700;

  logic clk;
  logic rst_n;

  sha256_in_if  in_ch ();
  sha256_out_if out_ch ();

  sha256_message_digest_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // Own model state: chain words, the partial block as bytes, the byte count.
  logic [31:0] chain_hash [8];
  logic [7:0]  block_bytes [64];
  logic [60:0] msg_bytes;

  byte_item_t   pending_bytes [$];
  digest_item_t digest_queue [$];

  int  failures;
  int  queued_count;
  int  idle_cycles;
  bit  stim_done;
  bit  in_taken;
  bit  out_taken;
  int  in_gap;
  int  out_gap;
  int  words_seen;
  bit  hold_done;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Compress the 64 buffered bytes into the chain words.
  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, ch, mj, t1;
    for (int i = 0; i < 16; i++)
      w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int k = 0; k < 8; k++) v[k] = chain_hash[k];
    for (int r = 0; r < 64; r++) begin
      s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
      ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
      t1 = v[7] + s1 + ch + sha256_pkg::ROUND_K[r] + w[r];
      s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
      mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
      v[0] = t1 + s0 + mj;
    end
    for (int k = 0; k < 8; k++) chain_hash[k] = chain_hash[k] + v[k];
  endfunction

  function automatic void place_byte(input logic [5:0] pos, input logic [7:0] b);
    block_bytes[pos] = b;
    if (pos == 6'd63) compress_block();
  endfunction

  function automatic void restart_digest();
    for (int k = 0; k < 8; k++) chain_hash[k] = sha256_pkg::INIT_HASH[k];
    msg_bytes = '0;
  endfunction

  // Advance the digest model by one accepted item; queue the words it yields.
  function automatic void predict_digest(input byte_item_t it);
    logic [63:0] bit_len;
    logic [5:0]  pos;
    digest_item_t d;
    if (it.byte_present) begin
      place_byte(msg_bytes[5:0], it.data_byte);
      msg_bytes = msg_bytes + 61'd1;
    end
    if (!it.message_end) return;
    bit_len = {msg_bytes, 3'b000};
    pos = msg_bytes[5:0];
    place_byte(pos, sha256_pkg::PAD_BYTE);
    pos = pos + 6'd1;
    while (pos != sha256_pkg::LEN_POS) begin
      place_byte(pos, 8'h00);
      pos = pos + 6'd1;
    end
    for (int k = 0; k < 8; k++) begin
      place_byte(pos, bit_len[63 - 8*k -: 8]);
      pos = pos + 6'd1;
    end
    for (int k = 0; k < 8; k++) begin
      d.word = chain_hash[k];
      d.last = (k == 7);
      digest_queue = {digest_queue, d};
    end
    restart_digest();
  endfunction

  task automatic queue_byte(input logic [7:0] b, input logic present, input logic last);
    byte_item_t it;
    it.data_byte    = b;
    it.byte_present = present;
    it.message_end  = last;
    pending_bytes = {pending_bytes, it};
    if (present || last) queued_count++;
  endtask

  // Queue a message of len random bytes, ending on the last byte or on a
  // separate end item; sprinkle empty items as noise.
  task automatic queue_message(input int len);
    bit end_on_byte;
    end_on_byte = (len > 0) && $urandom_range(0, 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) queue_byte(8'($urandom), 1'b0, 1'b0);
      queue_byte(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
    end
    if (!end_on_byte) queue_byte(8'($urandom), 1'b0, 1'b1);
  endtask

  // Stimulus: directed corner cases first, then random messages.
  initial begin
    int len;
    restart_digest();
    failures = 0;
    queued_count = 0;
    stim_done = 1'b0;
    // empty message, then an empty item that does nothing
    queue_byte(8'h00, 1'b0, 1'b1);
    queue_byte(8'hff, 1'b0, 1'b0);
    // "abc" with the end riding on the last byte
    queue_byte(8'h61, 1'b1, 1'b0);
    queue_byte(8'h62, 1'b1, 1'b0);
    queue_byte(8'h63, 1'b1, 1'b1);
    // single-byte messages, ff and 00 then a5, ended with and without a byte
    queue_byte(8'hff, 1'b1, 1'b1);
    queue_byte(8'h00, 1'b1, 1'b0);
    queue_byte(8'h5a, 1'b0, 1'b1);
    queue_byte(8'ha5, 1'b1, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h3c, 1'b0, 1'b1);
    while (queued_count < 360) begin
      case ($urandom_range(0, 5))
        0: len = 0;
        1: begin
          // lengths around the padding and block boundaries
          case ($urandom_range(0, 5))
            0: len = 55;
            1: len = 56;
            2: len = 63;
            3: len = 64;
            4: len = 119;
            default: len = 120;
          endcase
        end
        default: len = $urandom_range(1, 20);
      endcase
      queue_message(len);
    end
    stim_done = 1'b1;
  end

  // Reset and input defaults.
  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.byte_present = 1'b0;
    in_ch.message_end = 1'b0;
    out_ch.ready = 1'b0;
    in_gap = 0;
    out_gap = 0;
    words_seen = 0;
    hold_done = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
  end

  // Sample both handshakes at the rising edge; check results, feed the model.
  always @(posedge clk) begin
    digest_item_t exp_d;
    in_taken  = 1'b0;
    out_taken = 1'b0;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        in_taken = 1'b1;
        predict_digest(pending_bytes[0]);
      end
      if (out_ch.valid && out_ch.ready) begin
        out_taken = 1'b1;
        if (digest_queue.size() == 0) begin
          $display("%0t: unexpected digest item word=%h last=%b", $realtime,
                   out_ch.digest_word, out_ch.digest_last);
          failures++;
        end else begin
          exp_d = digest_queue.pop_front();
          if (out_ch.digest_word !== exp_d.word) begin
            $display("%0t: digest_word expected %h actual %h", $realtime,
                     exp_d.word, out_ch.digest_word);
            failures++;
          end
          if (out_ch.digest_last !== exp_d.last) begin
            $display("%0t: digest_last expected %b actual %b", $realtime,
                     exp_d.last, out_ch.digest_last);
            failures++;
          end
        end
      end
      // Watchdog: count cycles in which no item moves on either side.
      if (in_taken || out_taken) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // Driver: drop the accepted item, wait a random gap, present the next.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_taken) begin
        void'(pending_bytes.pop_front());
        in_gap = $urandom_range(0, 18);
        if ($urandom_range(0, 3) == 0) in_gap = 0;
        if (in_gap == 0 && pending_bytes.size() > 0) begin
          in_ch.data_byte    <= pending_bytes[0].data_byte;
          in_ch.byte_present <= pending_bytes[0].byte_present;
          in_ch.message_end  <= pending_bytes[0].message_end;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end else if (!in_ch.valid) begin
        if (in_gap > 0) in_gap--;
        else if (pending_bytes.size() > 0) begin
          in_ch.valid        <= 1'b1;
          in_ch.data_byte    <= pending_bytes[0].data_byte;
          in_ch.byte_present <= pending_bytes[0].byte_present;
          in_ch.message_end  <= pending_bytes[0].message_end;
        end
      end
    end
  end

  // Receiver: random stall per word; once, hold off long so the input backs up.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) begin
        words_seen++;
        out_gap = $urandom_range(0, 18);
        if ($urandom_range(0, 3) == 0) out_gap = 0;
        if (!hold_done && words_seen == 24) begin
          out_gap = HOLD_OFF;
          hold_done = 1'b1;
        end
      end else if (out_gap > 0) begin
        out_gap--;
      end
      out_ch.ready <= (out_gap == 0);
    end
  end

  // End of run: drain all expected words, let the block settle, report.
  initial begin
    idle_cycles = 0;
    wait (stim_done);
    wait (pending_bytes.size() == 0);
    wait (digest_queue.size() == 0);
    repeat (300) @(posedge clk);
    if (failures == 0 && digest_queue.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
